FILE: sv/pgsg_pkg.sv
package pgsg_pkg;

	localparam int UNIFORM_BITS_DEF = 16;

	localparam int SCALE_W   = 15;
	localparam int OFFSET_W  = 16;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCALE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RST = 15'd4096;

	// ln(2) in Q.32
	localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

	localparam int LOG_ITERS  = 24;
	localparam int DIV_ITERS  = 31;
	localparam int SQRT_ITERS = 28;
	localparam int CNT_W      = 5;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQA,
		OP_SQB,
		OP_RSUM,
		OP_NORM,
		OP_LOG,
		OP_LN,
		OP_DIVLD,
		OP_DIV,
		OP_SQLD,
		OP_SQRT,
		OP_MX,
		OP_SX,
		OP_MY,
		OP_SY,
		OP_FM,
		OP_FO
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic cache_full;
		logic reject;
		logic normed;
		logic out_busy;
	} dp_sts_t;

endpackage

FILE: sv/pgsg_ctrl.sv
module pgsg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pgsg_pkg::dp_sts_t  sts,
	output pgsg_pkg::dp_cmd_t  cmd
);

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_SQA  = 17'h00002,
		ST_SQB  = 17'h00004,
		ST_RSUM = 17'h00008,
		ST_NORM = 17'h00010,
		ST_LOG  = 17'h00020,
		ST_LN   = 17'h00040,
		ST_DVL  = 17'h00080,
		ST_DIV  = 17'h00100,
		ST_SQL  = 17'h00200,
		ST_SQRT = 17'h00400,
		ST_MX   = 17'h00800,
		ST_SX   = 17'h01000,
		ST_MY   = 17'h02000,
		ST_SY   = 17'h04000,
		ST_FM   = 17'h08000,
		ST_FO   = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic [pgsg_pkg::CNT_W-1:0] cnt_q, cnt_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = pgsg_pkg::OP_NOP;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = pgsg_pkg::OP_LOAD;
					state_d = sts.cache_full ? ST_FM : ST_SQA;
				end
			end
			ST_SQA: begin
				cmd.op  = pgsg_pkg::OP_SQA;
				state_d = ST_SQB;
			end
			ST_SQB: begin
				cmd.op  = pgsg_pkg::OP_SQB;
				state_d = ST_RSUM;
			end
			ST_RSUM: begin
				cmd.op  = pgsg_pkg::OP_RSUM;
				state_d = sts.reject ? ST_IDLE : ST_NORM;
			end
			ST_NORM: begin
				cmd.op = pgsg_pkg::OP_NORM;
				if (sts.normed) begin
					state_d = ST_LOG;
					cnt_d   = pgsg_pkg::CNT_W'(pgsg_pkg::LOG_ITERS - 1);
				end
			end
			ST_LOG: begin
				cmd.op = pgsg_pkg::OP_LOG;
				if (cnt_q == '0) begin
					state_d = ST_LN;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_LN: begin
				cmd.op  = pgsg_pkg::OP_LN;
				state_d = ST_DVL;
			end
			ST_DVL: begin
				cmd.op  = pgsg_pkg::OP_DIVLD;
				state_d = ST_DIV;
				cnt_d   = pgsg_pkg::CNT_W'(pgsg_pkg::DIV_ITERS - 1);
			end
			ST_DIV: begin
				cmd.op = pgsg_pkg::OP_DIV;
				if (cnt_q == '0) begin
					state_d = ST_SQL;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_SQL: begin
				cmd.op  = pgsg_pkg::OP_SQLD;
				state_d = ST_SQRT;
				cnt_d   = pgsg_pkg::CNT_W'(pgsg_pkg::SQRT_ITERS - 1);
			end
			ST_SQRT: begin
				cmd.op = pgsg_pkg::OP_SQRT;
				if (cnt_q == '0) begin
					state_d = ST_MX;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_MX: begin
				cmd.op  = pgsg_pkg::OP_MX;
				state_d = ST_SX;
			end
			ST_SX: begin
				cmd.op  = pgsg_pkg::OP_SX;
				state_d = ST_MY;
			end
			ST_MY: begin
				cmd.op  = pgsg_pkg::OP_MY;
				state_d = ST_SY;
			end
			ST_SY: begin
				cmd.op  = pgsg_pkg::OP_SY;
				state_d = ST_FM;
			end
			ST_FM: begin
				cmd.op  = pgsg_pkg::OP_FM;
				state_d = ST_FO;
			end
			ST_FO: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.op  = pgsg_pkg::OP_FO;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_cached_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && sts.cache_full) |=> (state_q == ST_FM))
		else $error("cached request did not take the short path");

	a_reject_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RSUM && sts.reject) |=> (state_q == ST_IDLE))
		else $error("rejected pair did not return to idle");

	a_loop_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT && cnt_q == '0) |=> (state_q == ST_MX))
		else $error("root loop did not end on count");

endmodule

FILE: sv/pgsg_dp.sv
module pgsg_dp #(
	parameter int UNIFORM_BITS = pgsg_pkg::UNIFORM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pgsg_pkg::dp_cmd_t                   cmd,
	output pgsg_pkg::dp_sts_t                   sts,
	input  logic [UNIFORM_BITS-1:0]             uniform_a,
	input  logic [UNIFORM_BITS-1:0]             uniform_b,
	input  logic                                cfg_wr_en,
	input  logic [pgsg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pgsg_pkg::CFG_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pgsg_pkg::SAMPLE_W-1:0] sample,
	output logic                                from_cache
);

	localparam int U     = UNIFORM_BITS;
	localparam int SQ_W  = 2 * U;
	localparam int R_SH  = 64 - SQ_W;
	localparam int D_SH  = 32 - U;
	localparam logic [SQ_W-1:0] R_ONE = {2'b01, {(SQ_W-2){1'b0}}};

	// configuration and control state
	logic [pgsg_pkg::SCALE_W-1:0]         scale_q;
	logic signed [pgsg_pkg::OFFSET_W-1:0] offset_q;
	logic                                 cache_full_q;
	logic                                 out_valid_q;

	// payload
	logic [U-1:0]  amag_q, bmag_q;
	logic          asgn_q, bsgn_q;
	logic          fc_q;
	logic [63:0]   mul_q;
	logic [SQ_W-1:0] sum_q;
	logic [62:0]   norm_q;
	logic [5:0]    s_q;
	logic [30:0]   m_q;
	logic [23:0]   lg_q;
	logic [31:0]   rem_q;
	logic [30:0]   q_q;
	logic [55:0]   vsh_q;
	logic [27:0]   root_q;
	logic [28:0]   srem_q;
	logic [15:0]   xd_q;
	logic [15:0]   cache_q;
	logic          vneg_q;
	logic [15:0]   sample_q;
	logic          from_cache_q;

	// combinational
	logic [31:0]   mop_a, mop_b;
	logic [63:0]   prod_c;
	logic [SQ_W-1:0] sum_c;
	logic [63:0]   r64;
	logic [U-1:0]  as_c, bs_c;
	logic [31:0]   sq_c;
	logic [29:0]   negl_c;
	logic [30:0]   m0_c;
	logic          dge_c;
	logic [31:0]   dif_c;
	logic [31:0]   u2_c;
	logic [30:0]   rem2_c, trial_c;
	logic          sge_c;
	logic [30:0]   snext_c;
	logic [15:0]   draw_c;
	logic [15:0]   fv_c, fmag_c;
	logic [31:0]   t32_c;
	logic signed [21:0] tv_c, tot_c;
	logic [15:0]   fin_c;

	function automatic logic [15:0] draw(input logic [63:0] p, input logic [4:0] h,
		input logic neg);
		logic [63:0] full, bias, rq;
		logic [5:0]  sh;
		logic [15:0] res;
		full = p << D_SH;
		sh   = 6'd43 - {1'b0, h};
		bias = 64'd1 << (sh - 6'd1);
		rq   = (full + bias) >> sh;
		if (neg) begin
			res = (rq >= 64'd32768) ? 16'h8000 : 16'(-rq[15:0]);
		end else begin
			res = (rq > 64'd32767) ? 16'h7FFF : rq[15:0];
		end
		return res;
	endfunction

	assign as_c = {~uniform_a[U-1], uniform_a[U-2:0]};
	assign bs_c = {~uniform_b[U-1], uniform_b[U-2:0]};

	always_comb begin
		case (cmd.op)
			pgsg_pkg::OP_SQA: begin
				mop_a = 32'(amag_q);
				mop_b = 32'(amag_q);
			end
			pgsg_pkg::OP_SQB: begin
				mop_a = 32'(bmag_q);
				mop_b = 32'(bmag_q);
			end
			pgsg_pkg::OP_LOG: begin
				mop_a = {1'b0, m_q};
				mop_b = {1'b0, m_q};
			end
			pgsg_pkg::OP_LN: begin
				mop_a = {2'b00, negl_c};
				mop_b = pgsg_pkg::LN2_Q32;
			end
			pgsg_pkg::OP_MX: begin
				mop_a = 32'(amag_q);
				mop_b = {4'b0, root_q};
			end
			pgsg_pkg::OP_MY: begin
				mop_a = 32'(bmag_q);
				mop_b = {4'b0, root_q};
			end
			pgsg_pkg::OP_FM: begin
				mop_a = {16'b0, fmag_c};
				mop_b = {17'b0, scale_q};
			end
			default: begin
				mop_a = '0;
				mop_b = '0;
			end
		endcase
	end

	assign prod_c = 64'(mop_a) * 64'(mop_b);

	assign sum_c = sum_q + mul_q[SQ_W-1:0];
	assign r64   = 64'(sum_c) << R_SH;

	assign sq_c   = prod_c[61:30];
	assign negl_c = {s_q, 24'b0} - {6'b0, lg_q};
	assign m0_c   = norm_q[62:32];

	assign dge_c = (rem_q >= {1'b0, m0_c});
	assign dif_c = dge_c ? (rem_q - {1'b0, m0_c}) : rem_q;

	assign u2_c = s_q[0] ? {q_q, 1'b0} : {1'b0, q_q};

	// one root bit per beat of the digit recurrence
	assign rem2_c  = {srem_q, vsh_q[55:54]};
	assign trial_c = {1'b0, root_q, 2'b01};
	assign sge_c   = (rem2_c >= trial_c);
	assign snext_c = sge_c ? (rem2_c - trial_c) : rem2_c;

	assign draw_c = draw(mul_q, s_q[5:1], (cmd.op == pgsg_pkg::OP_SX) ? asgn_q : bsgn_q);

	assign fv_c   = fc_q ? cache_q : xd_q;
	assign fmag_c = fv_c[15] ? 16'(-fv_c) : fv_c;

	// round half away from zero, add mean, saturate
	assign t32_c = 32'(mul_q[30:0]) + 32'd2048;
	assign tv_c  = vneg_q ? -$signed({2'b00, t32_c[31:12]}) : $signed({2'b00, t32_c[31:12]});
	assign tot_c = tv_c + 22'(offset_q);
	always_comb begin
		if (tot_c > 22'sd32767) begin
			fin_c = 16'h7FFF;
		end else if (tot_c < -22'sd32768) begin
			fin_c = 16'h8000;
		end else begin
			fin_c = tot_c[15:0];
		end
	end

	assign sts.cache_full = cache_full_q;
	assign sts.reject     = (sum_c == '0) || (sum_c > R_ONE);
	assign sts.normed     = norm_q[62];
	assign sts.out_busy   = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= pgsg_pkg::SCALE_RST;
			offset_q     <= '0;
			cache_full_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					pgsg_pkg::CFG_IDX_SCALE:  scale_q  <= cfg_data[pgsg_pkg::SCALE_W-1:0];
					pgsg_pkg::CFG_IDX_OFFSET: offset_q <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (cmd.op == pgsg_pkg::OP_SY) begin
				cache_full_q <= 1'b1;
			end else if (cmd.op == pgsg_pkg::OP_FO && fc_q) begin
				cache_full_q <= 1'b0;
			end
			if (cmd.op == pgsg_pkg::OP_FO) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			pgsg_pkg::OP_LOAD: begin
				asgn_q <= as_c[U-1];
				bsgn_q <= bs_c[U-1];
				amag_q <= as_c[U-1] ? U'(-as_c) : as_c;
				bmag_q <= bs_c[U-1] ? U'(-bs_c) : bs_c;
				fc_q   <= cache_full_q;
			end
			pgsg_pkg::OP_SQA: begin
				mul_q <= prod_c;
			end
			pgsg_pkg::OP_SQB: begin
				sum_q <= mul_q[SQ_W-1:0];
				mul_q <= prod_c;
			end
			pgsg_pkg::OP_RSUM: begin
				norm_q <= r64[62:0];
				s_q    <= '0;
			end
			pgsg_pkg::OP_NORM: begin
				if (norm_q[62]) begin
					m_q  <= norm_q[62:32];
					lg_q <= '0;
				end else begin
					norm_q <= {norm_q[61:0], 1'b0};
					s_q    <= s_q + 6'd1;
				end
			end
			pgsg_pkg::OP_LOG: begin
				m_q  <= sq_c[31] ? sq_c[31:1] : sq_c[30:0];
				lg_q <= {lg_q[22:0], sq_c[31]};
			end
			pgsg_pkg::OP_LN: begin
				mul_q <= prod_c;
			end
			pgsg_pkg::OP_DIVLD: begin
				rem_q <= {1'b0, mul_q[61:31]};
				q_q   <= '0;
			end
			pgsg_pkg::OP_DIV: begin
				rem_q <= {dif_c[30:0], 1'b0};
				q_q   <= {q_q[29:0], dge_c};
			end
			pgsg_pkg::OP_SQLD: begin
				vsh_q  <= {u2_c, 24'b0};
				root_q <= '0;
				srem_q <= '0;
			end
			pgsg_pkg::OP_SQRT: begin
				srem_q <= snext_c[28:0];
				root_q <= {root_q[26:0], sge_c};
				vsh_q  <= {vsh_q[53:0], 2'b00};
			end
			pgsg_pkg::OP_MX, pgsg_pkg::OP_MY: begin
				mul_q <= prod_c;
			end
			pgsg_pkg::OP_SX: begin
				xd_q <= draw_c;
			end
			pgsg_pkg::OP_SY: begin
				cache_q <= draw_c;
			end
			pgsg_pkg::OP_FM: begin
				mul_q  <= prod_c;
				vneg_q <= fv_c[15];
			end
			pgsg_pkg::OP_FO: begin
				sample_q     <= fin_c;
				from_cache_q <= fc_q;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign sample     = $signed(sample_q);
	assign from_cache = from_cache_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pgsg_pkg::OP_FO) |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_cache_set: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pgsg_pkg::OP_SY) |=> cache_full_q)
		else $error("cache not marked full after pair");

	a_cache_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pgsg_pkg::OP_FO && fc_q) |=> (!cache_full_q && out_valid_q && from_cache_q))
		else $error("cached beat not emitted or cache not cleared");

endmodule

FILE: sv/polar_gaussian_sample_generator.sv
// A cached request goes straight to the final scale and output steps; a fresh pair passes
// through the bit-serial normalizer (one shift per leading zero of r, 0..30), 24 log squarings,
// the 31-step divider and the 28-step root, all on one multiplier; a rejected pair gives none.
// One request in flight: the next beat is taken only once the current one is done, and later
// while a finished result waits for the output register. Reset clears the cache, the output
// valid, scale to 1.0 and offset to 0.
module polar_gaussian_sample_generator #(
	parameter int UNIFORM_BITS = pgsg_pkg::UNIFORM_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [UNIFORM_BITS-1:0]              uniform_a,
	input  logic [UNIFORM_BITS-1:0]              uniform_b,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pgsg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 from_cache,
	input  logic                                 cfg_wr_en,
	input  logic [pgsg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pgsg_pkg::CFG_W-1:0]           cfg_data
);

	pgsg_pkg::dp_cmd_t cmd;
	pgsg_pkg::dp_sts_t sts;

	pgsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pgsg_dp #(
		.UNIFORM_BITS(UNIFORM_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.uniform_a  (uniform_a),
		.uniform_b  (uniform_b),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.from_cache (from_cache)
	);

endmodule
